FILE: rtl/core/lsltm_pkg.sv
// shared types and constants of the line/time mapper
package lsltm_pkg;

    localparam int S_TDATA_W = 232;
    localparam int M_TDATA_W = 96;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 64;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_L2T  = 2'd1;
    localparam logic [1:0] OP_T2L  = 2'd2;

    localparam logic [1:0] STS_OK         = 2'd0;
    localparam logic [1:0] STS_NOT_LOADED = 2'd1;
    localparam logic [1:0] STS_OUTSIDE    = 2'd2;
    localparam logic [1:0] STS_FAULT      = 2'd3;

    localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_LINES  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_RECORD_COUNT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_CENTER_TIME  = 2'd2;

    typedef struct packed {
        logic capture;
        logic prep;
        logic scan_issue;
        logic l2t_a;
        logic mul_hi;
        logic mul_lo;
        logic l2t_sum;
        logic l2t_fin;
        logic t2l_a;
        logic t2l_csm;
        logic t2l_fin;
        logic push;
    } lsltm_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       prep_done;
        logic       scan_last;
        logic       t2l_err;
        logic       div_done;
        logic       out_free;
    } lsltm_sts_t;

endpackage

FILE: rtl/core/line_scan_line_time_mapper.sv
// Line-scan line/time mapper with a table of variable line-rate records.
// Input stream s_*: s_tuser carries the opcode (0 load record, 1 line to
// time, 2 time to line, 3 ignored); s_tdata carries the record fields, the
// queried line or time and the pixel convention flag. Every transaction
// gives exactly one result on m_*: m_tuser is the status, m_tdata the time
// and the line result. Registers image_lines, record_count and center_time
// are to be written through cfg_wr_en/cfg_addr/cfg_wdata only while the
// block is idle; the block itself does not enforce this. One item is
// worked at a time, s_tready is high only when idle, so the next
// transaction is taken at the earliest in the cycle after the result is
// pushed. A load or an early status goes from the prep step straight to
// the output; a line-to-time query scans the records (one table read per
// cycle) and then runs the multiply and sum steps; a time-to-line query
// scans too and runs the 2-bit-per-cycle divider unless its record faults.
// The result sits in an output register; the next item is accepted while it
// waits, and a stalled receiver holds that item at its final step.
// Synchronous reset clears the config registers, the scan and divider control,
// m_tvalid and the controller; table contents stay undefined until loaded.
module line_scan_line_time_mapper #(
    parameter int MAX_RECORDS        = 16,
    parameter int LINE_FRACTION_BITS = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // record_index, record_start_line, record_start_time, record_line_period,
    // line_value, time_value, zero_based, zero fill
    input  logic [lsltm_pkg::S_TDATA_W-1:0]  s_tdata,
    // opcode
    input  logic [1:0]                       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // time_result, line_result
    output logic [lsltm_pkg::M_TDATA_W-1:0]  m_tdata,
    // status
    output logic [1:0]                       m_tuser,
    input  logic                             cfg_wr_en,
    input  logic [lsltm_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [lsltm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import lsltm_pkg::*;

    lsltm_cmd_t cmd;
    lsltm_sts_t sts;

    lsltm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lsltm_datapath #(
        .MAX_RECORDS        (MAX_RECORDS),
        .LINE_FRACTION_BITS (LINE_FRACTION_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

FILE: rtl/core/lsltm_ram.sv
// generic simple dual-port ram with registered read
module lsltm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/lsltm_divider.sv
// radix-4 restoring divider, 64-bit numerator extended by zero fraction bits
module lsltm_divider #(
    parameter int EXT_W = 17,
    parameter int QUO_W = 42
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [63:0]      numer,
    input  logic [31:0]      denom,
    output logic             done,
    output logic [QUO_W-1:0] quo,
    output logic             over
);

    localparam int DW    = 64 + EXT_W;
    localparam int DWE   = DW + (DW % 2);
    localparam int STEPS = DWE / 2;
    localparam int CW    = $clog2(STEPS + 1);

    logic [DWE-1:0]   dvd_reg;
    logic [31:0]      den_reg;
    logic [31:0]      rem_reg;
    logic [QUO_W-1:0] quo_reg;
    logic             over_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [32:0] r1, r1s, r2, r2s;
    logic        q1, q2;

    always_comb begin
        r1  = {rem_reg, dvd_reg[DWE-1]};
        q1  = (r1 >= {1'b0, den_reg});
        r1s = q1 ? (r1 - {1'b0, den_reg}) : r1;
        r2  = {r1s[31:0], dvd_reg[DWE-2]};
        q2  = (r2 >= {1'b0, den_reg});
        r2s = q2 ? (r2 - {1'b0, den_reg}) : r2;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + CW'(1);
            if (cnt_reg == CW'(STEPS - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg  <= DWE'({numer, {EXT_W{1'b0}}});
            den_reg  <= denom;
            rem_reg  <= '0;
            quo_reg  <= '0;
            over_reg <= 1'b0;
        end else if (busy_reg) begin
            dvd_reg  <= dvd_reg << 2;
            rem_reg  <= r2s[31:0];
            quo_reg  <= {quo_reg[QUO_W-3:0], q1, q2};
            // quotient bits pushed out of the top mean a far result
            over_reg <= over_reg | quo_reg[QUO_W-1] | quo_reg[QUO_W-2];
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign over = over_reg;

endmodule

FILE: rtl/core/lsltm_datapath.sv
// datapath: config registers, record table, search, multiply, divide, output register
module lsltm_datapath #(
    parameter int MAX_RECORDS        = 16,
    parameter int LINE_FRACTION_BITS = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [lsltm_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [lsltm_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic [lsltm_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [1:0]                       s_tuser,
    input  lsltm_pkg::lsltm_cmd_t            cmd,
    output lsltm_pkg::lsltm_sts_t            sts,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [lsltm_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [1:0]                       m_tuser
);
    import lsltm_pkg::*;

    localparam int F  = LINE_FRACTION_BITS;
    localparam int LW = F + 28;
    localparam int AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    localparam int CW = $clog2(MAX_RECORDS + 1);
    localparam int QW = F + 26;
    localparam int MB = 27;
    localparam int PW = 32 + MB;
    localparam int EW = 127;
    localparam logic [LW-1:0] HALF_LINE = LW'(1) << (F - 1);
    localparam logic [PW-1:0] ROUND_LO  = PW'(1) << (F - 1);

    // configuration
    logic [14:0] image_lines_reg;
    logic [4:0]  record_count_reg;
    logic [63:0] center_time_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_lines_reg  <= '0;
            record_count_reg <= '0;
            center_time_reg  <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_IMAGE_LINES:  image_lines_reg  <= cfg_wdata[14:0];
                CFG_RECORD_COUNT: record_count_reg <= cfg_wdata[4:0];
                CFG_CENTER_TIME:  center_time_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // captured transaction
    logic [1:0]  op_reg;
    logic [3:0]  idx_reg;
    logic [30:0] rsl_reg;
    logic [63:0] rst_reg;
    logic [31:0] rp_reg;
    logic [31:0] line_reg;
    logic [63:0] time_reg;
    logic        zb_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg   <= s_tuser;
            idx_reg  <= s_tdata[3:0];
            rsl_reg  <= s_tdata[34:4];
            rst_reg  <= s_tdata[98:35];
            rp_reg   <= s_tdata[130:99];
            line_reg <= s_tdata[162:131];
            time_reg <= s_tdata[226:163];
            zb_reg   <= s_tdata[227];
        end
    end

    // common derived values
    logic [CW-1:0] n_eff;
    logic          n_zero;
    logic [LW-1:0] max_csm;
    logic [LW-1:0] zb_shift;
    logic [LW-1:0] csm_in;
    logic [63:0]   rel_in;
    logic          rel_ov;
    logic          idx_ok;

    always_comb begin
        if (32'(record_count_reg) > MAX_RECORDS) begin
            n_eff = CW'(MAX_RECORDS);
        end else begin
            n_eff = CW'(record_count_reg);
        end
        n_zero   = (record_count_reg == 5'd0);
        max_csm  = (LW'(image_lines_reg) << F) - HALF_LINE;
        zb_shift = zb_reg ? HALF_LINE : '0;
        csm_in   = {{(LW-32){line_reg[31]}}, line_reg} + zb_shift;
        rel_in   = time_reg - center_time_reg;
        rel_ov   = (time_reg[63] != center_time_reg[63]) && (rel_in[63] != time_reg[63]);
        idx_ok   = (32'(idx_reg) < MAX_RECORDS);
    end

    // record table
    logic [CW-1:0] issue_cnt_reg;
    logic          rd_vld_reg;
    logic          rd_first_reg;
    logic [EW-1:0] ram_rdata;
    logic          ram_we;

    assign ram_we = cmd.prep && (op_reg == OP_LOAD) && idx_ok;

    lsltm_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_RECORDS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (AW'(idx_reg)),
        .wdata ({rsl_reg, rst_reg, rp_reg}),
        .raddr (issue_cnt_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issue_cnt_reg <= '0;
            rd_vld_reg    <= 1'b0;
            rd_first_reg  <= 1'b0;
        end else begin
            rd_vld_reg   <= cmd.scan_issue;
            rd_first_reg <= cmd.scan_issue && (issue_cnt_reg == '0);
            if (cmd.prep) begin
                issue_cnt_reg <= '0;
            end else if (cmd.scan_issue) begin
                issue_cnt_reg <= issue_cnt_reg + CW'(1);
            end
        end
    end

    // search: keep the last record that the query has reached, or the first record if none is reached
    logic [30:0]   ram_sl;
    logic [63:0]   ram_st;
    logic [31:0]   ram_p;
    logic [63:0]   sd;
    logic          sd_ov;
    logic          reached;
    logic [LW-1:0] csm_reg;
    logic [63:0]   rel_reg;
    logic [30:0]   best_sl_reg;
    logic [63:0]   best_st_reg;
    logic [31:0]   best_p_reg;

    always_comb begin
        ram_sl = ram_rdata[126:96];
        ram_st = ram_rdata[95:32];
        ram_p  = ram_rdata[31:0];
        sd     = rel_reg - ram_st;
        sd_ov  = (rel_reg[63] != ram_st[63]) && (sd[63] != rel_reg[63]);
        if (op_reg == OP_L2T) begin
            reached = $signed({{(LW-31){1'b0}}, ram_sl}) <= $signed(csm_reg);
        end else if (sd_ov) begin
            reached = !rel_reg[63];
        end else begin
            reached = !sd[63] && ({sd, 1'b0} >= {33'd0, ram_p});
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_vld_reg && (rd_first_reg || reached)) begin
            best_sl_reg <= ram_sl;
            best_st_reg <= ram_st;
            best_p_reg  <= ram_p;
        end
    end

    // line to time arithmetic
    logic [LW-1:0] diff;
    logic [LW-2:0] mag_reg;
    logic          neg_reg;
    logic [63:0]   base;
    logic [63:0]   base_reg;
    logic          base_ov_reg;
    logic [MB-1:0] mul_b;
    logic [PW-1:0] product;
    logic [PW-1:0] prod_hi_reg;
    logic [PW-1:0] prod_lo_reg;
    logic [PW-1:0] lo_round;
    logic [63:0]   prod;
    logic [63:0]   term_reg;
    logic [63:0]   total;
    logic          total_ov;

    always_comb begin
        diff     = csm_reg - {{(LW-31){1'b0}}, best_sl_reg} + HALF_LINE;
        base     = center_time_reg + best_st_reg;
        mul_b    = cmd.mul_hi ? MB'(mag_reg[LW-2:F]) : MB'(mag_reg[F-1:0]);
        product  = PW'(best_p_reg) * PW'(mul_b);
        lo_round = (prod_lo_reg + ROUND_LO) >> F;
        prod     = 64'(prod_hi_reg) + 64'(lo_round);
        total    = base_reg + term_reg;
        total_ov = (base_reg[63] == term_reg[63]) && (total[63] != base_reg[63]);
    end

    // time to line arithmetic
    logic [63:0]   d;
    logic          d_ov;
    logic          t2l_err;
    logic [63:0]   dmag;
    logic          div_done;
    logic [QW-1:0] quo;
    logic          div_over;
    logic [24:0]   qi;
    logic [F:0]    frac;
    logic [F+1:0]  frac_rnd;
    logic [QW-1:0] q;
    logic [LW-1:0] q_ext;
    logic          far;
    logic          far_reg;
    logic [LW-1:0] csm2;
    logic [LW-1:0] conv;
    logic          conv_fits;
    logic          csm_in_ok;
    logic          csm_reg_ok;

    always_comb begin
        d         = rel_reg - best_st_reg;
        d_ov      = (rel_reg[63] != best_st_reg[63]) && (d[63] != rel_reg[63]);
        t2l_err   = d_ov || (best_p_reg == 32'd0);
        dmag      = d[63] ? (64'd0 - d) : d;
        qi        = quo[F+25:F+1];
        frac      = quo[F:0];
        frac_rnd  = ({1'b0, frac} + (F+2)'(1)) >> 1;
        q         = QW'({qi, {F{1'b0}}}) + QW'(frac_rnd);
        q_ext     = LW'(q);
        far       = div_over || (qi[24] && (|qi[23:0]));
        csm2      = {{(LW-31){1'b0}}, best_sl_reg} - HALF_LINE
                    + (neg_reg ? (LW'(0) - q_ext) : q_ext);
        conv      = csm_reg - zb_shift;
        conv_fits = (&conv[LW-1:31]) || !(|conv[LW-1:31]);
        csm_in_ok = !($signed(csm_in) < $signed(HALF_LINE))
                    && !($signed(csm_in) > $signed(max_csm));
        csm_reg_ok = !($signed(csm_reg) < $signed(HALF_LINE))
                    && !($signed(csm_reg) > $signed(max_csm));
    end

    lsltm_divider #(
        .EXT_W (F + 1),
        .QUO_W (QW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.t2l_a && !t2l_err),
        .numer   (dmag),
        .denom   (best_p_reg),
        .done    (div_done),
        .quo     (quo),
        .over    (div_over)
    );

    // early outcome of the prep step
    logic       prep_done;
    logic [1:0] prep_status;

    always_comb begin
        prep_done   = 1'b1;
        prep_status = STS_OK;
        case (op_reg)
            OP_L2T: begin
                if (n_zero) begin
                    prep_status = STS_NOT_LOADED;
                end else if (!csm_in_ok) begin
                    prep_status = STS_OUTSIDE;
                end else begin
                    prep_done = 1'b0;
                end
            end
            OP_T2L: begin
                if (n_zero) begin
                    prep_status = STS_NOT_LOADED;
                end else if (rel_ov) begin
                    prep_status = STS_FAULT;
                end else begin
                    prep_done = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // working registers and pending result
    logic [1:0]  res_status_reg;
    logic [63:0] res_time_reg;
    logic [31:0] res_line_reg;

    always_ff @(posedge aclk) begin
        if (cmd.prep) begin
            csm_reg        <= csm_in;
            rel_reg        <= rel_in;
            res_status_reg <= prep_status;
            res_time_reg   <= '0;
            res_line_reg   <= '0;
        end
        if (cmd.l2t_a) begin
            neg_reg     <= diff[LW-1];
            mag_reg     <= diff[LW-1] ? (LW-1)'(LW'(0) - diff) : diff[LW-2:0];
            base_reg    <= base;
            base_ov_reg <= (center_time_reg[63] == best_st_reg[63])
                           && (base[63] != center_time_reg[63]);
        end
        if (cmd.mul_hi) begin
            prod_hi_reg <= product;
        end
        if (cmd.mul_lo) begin
            prod_lo_reg <= product;
        end
        if (cmd.l2t_sum) begin
            term_reg <= neg_reg ? (64'd0 - prod) : prod;
        end
        if (cmd.l2t_fin) begin
            if (base_ov_reg || total_ov) begin
                res_status_reg <= STS_FAULT;
            end else begin
                res_status_reg <= STS_OK;
                res_time_reg   <= total;
            end
        end
        if (cmd.t2l_a) begin
            neg_reg <= d[63];
            if (t2l_err) begin
                res_status_reg <= STS_FAULT;
            end
        end
        if (cmd.t2l_csm) begin
            csm_reg <= csm2;
            far_reg <= far;
        end
        if (cmd.t2l_fin) begin
            if (far_reg || !csm_reg_ok) begin
                res_status_reg <= STS_OUTSIDE;
            end else if (!conv_fits) begin
                res_status_reg <= STS_FAULT;
            end else begin
                res_status_reg <= STS_OK;
                res_line_reg   <= conv[31:0];
            end
        end
    end

    // output register
    logic        m_tvalid_reg;
    logic [1:0]  m_status_reg;
    logic [63:0] m_time_reg;
    logic [31:0] m_line_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.push) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            m_status_reg <= res_status_reg;
            m_time_reg   <= res_time_reg;
            m_line_reg   <= res_line_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {m_line_reg, m_time_reg};

    always_comb begin
        sts.op        = op_reg;
        sts.prep_done = prep_done;
        sts.scan_last = (issue_cnt_reg == (n_eff - CW'(1)));
        sts.t2l_err   = t2l_err;
        sts.div_done  = div_done;
        sts.out_free  = !m_tvalid_reg || m_tready;
    end

endmodule

FILE: rtl/core/lsltm_ctrl.sv
// controller state machine sequencing the datapath
module lsltm_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  lsltm_pkg::lsltm_sts_t sts,
    output lsltm_pkg::lsltm_cmd_t cmd
);
    import lsltm_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_PREP     = 4'd1;
    localparam logic [3:0] S_SCAN     = 4'd2;
    localparam logic [3:0] S_SCAN_END = 4'd3;
    localparam logic [3:0] S_L2T_A    = 4'd4;
    localparam logic [3:0] S_MUL_HI   = 4'd5;
    localparam logic [3:0] S_MUL_LO   = 4'd6;
    localparam logic [3:0] S_L2T_SUM  = 4'd7;
    localparam logic [3:0] S_L2T_FIN  = 4'd8;
    localparam logic [3:0] S_T2L_A    = 4'd9;
    localparam logic [3:0] S_DIV      = 4'd10;
    localparam logic [3:0] S_T2L_CSM  = 4'd11;
    localparam logic [3:0] S_T2L_FIN  = 4'd12;
    localparam logic [3:0] S_OUT      = 4'd13;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_PREP;
                end
            end
            S_PREP: begin
                cmd.prep   = 1'b1;
                state_next = sts.prep_done ? S_OUT : S_SCAN;
            end
            S_SCAN: begin
                cmd.scan_issue = 1'b1;
                if (sts.scan_last) begin
                    state_next = S_SCAN_END;
                end
            end
            S_SCAN_END: begin
                // last table read lands here
                state_next = (sts.op == OP_L2T) ? S_L2T_A : S_T2L_A;
            end
            S_L2T_A: begin
                cmd.l2t_a  = 1'b1;
                state_next = S_MUL_HI;
            end
            S_MUL_HI: begin
                cmd.mul_hi = 1'b1;
                state_next = S_MUL_LO;
            end
            S_MUL_LO: begin
                cmd.mul_lo = 1'b1;
                state_next = S_L2T_SUM;
            end
            S_L2T_SUM: begin
                cmd.l2t_sum = 1'b1;
                state_next  = S_L2T_FIN;
            end
            S_L2T_FIN: begin
                cmd.l2t_fin = 1'b1;
                state_next  = S_OUT;
            end
            S_T2L_A: begin
                cmd.t2l_a  = 1'b1;
                state_next = sts.t2l_err ? S_OUT : S_DIV;
            end
            S_DIV: begin
                if (sts.div_done) begin
                    state_next = S_T2L_CSM;
                end
            end
            S_T2L_CSM: begin
                cmd.t2l_csm = 1'b1;
                state_next  = S_T2L_FIN;
            end
            S_T2L_FIN: begin
                cmd.t2l_fin = 1'b1;
                state_next  = S_OUT;
            end
            S_OUT: begin
                if (sts.out_free) begin
                    cmd.push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
